// ----- src/cir_pkg.sv -----
// Package: shared constants, types and codes of the chunked image reassembler.
package cir_pkg;

  localparam int unsigned BUFFER_BYTES = 65536;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int unsigned PTR_W        = ADDR_W + 1;
  localparam logic [15:0] MAGIC_RESET  = 16'hFECA;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_BYTE   = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_IGNORED      = 4'd1,
    ST_EMPTY        = 4'd2,
    ST_BAD_MAGIC    = 4'd3,
    ST_TOO_LARGE    = 4'd4,
    ST_BAD_INDEX    = 4'd5,
    ST_MISMATCH     = 4'd6,
    ST_OVERFLOW     = 4'd7,
    ST_NOT_COMPLETE = 4'd8,
    ST_OUT_OF_RANGE = 4'd9
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] magic_value;
    logic [31:0] image_length;
    logic [15:0] chunk_index;
    logic [15:0] chunk_count;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic [15:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  read_data;
    logic        frame_complete;
    logic [15:0] chunks_seen;
    logic [16:0] assembled_length;
  } out_item_t;

endpackage

// ----- src/cir_if.sv -----
// Interfaces: valid/ready channels for input items and result items.
interface cir_in_if;
  logic               valid;
  logic               ready;
  cir_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cir_out_if;
  logic               valid;
  logic               ready;
  cir_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/cir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cir_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/chunked_image_reassembler.sv -----
// Top level: chunked image reassembler with frame control and image buffer.
//
// Items enter on in_i and each produces exactly one result on out_o; both
// channels transfer at a rising edge with valid and ready high. The header
// magic is written through cfg_we_i/cfg_wdata_i; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// A payload byte or clear item has its result registered at the transfer
// edge, so payload bytes stream into the buffer at one per cycle while the
// receiver keeps ready high. For a header, the chunk offset product is
// registered first, then the range check and frame update complete.
// For a read, the buffer RAM read data is registered before the result is formed.
// The result register holds one item; a new item is taken while the held
// result transfers out, and ready drops while a result waits on a stalled
// receiver.
// Reset clears the frame state and restores the header magic to 0xFECA; the
// image buffer is not cleared, and bytes never written read back undefined.
module chunked_image_reassembler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  cir_in_if.sink            in_i,
  cir_out_if.source         out_o
);

  localparam int unsigned AW = cir_pkg::ADDR_W;
  localparam int unsigned PW = cir_pkg::PTR_W;
  localparam logic [PW-1:0] BUF_END = PW'(cir_pkg::BUFFER_BYTES);

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_HDR  = 3'b010,
    FSM_RD   = 3'b100
  } fsm_e;

  fsm_e fsm_q, fsm_d;

  logic [15:0]   magic_q;
  logic          active_q, active_d;
  logic          done_q, done_d;
  logic [PW-1:0] flen_q, flen_d;
  logic [15:0]   exp_q, exp_d;
  logic [15:0]   rcv_q, rcv_d;
  logic [15:0]   bpc_q, bpc_d;
  logic [PW-1:0] wptr_q, wptr_d;
  logic [15:0]   left_q, left_d;
  logic          acc_q, acc_d;

  cir_pkg::in_item_t hdr_q;
  logic [31:0]       prod_q;
  logic [3:0]        rd_status_q, rd_status_d;

  logic               out_valid_q, out_valid_d;
  cir_pkg::out_item_t out_data_q, out_data_d;

  logic            take;
  logic            load;
  logic [3:0]      status;
  logic [7:0]      rdata;
  logic            ram_we;
  logic            ram_re;
  logic [7:0]      ram_rdata;
  logic [32:0]     end_off;
  logic [PW-1:0]   flen_cmp;
  logic [15:0]     exp_cmp;
  logic            act_cmp;
  logic            done_cmp;
  logic [15:0]     rcv_cmp;
  logic [15:0]     rcv_inc;

  assign in_i.ready  = (fsm_q == FSM_IDLE) && (!out_valid_q || out_o.ready);
  assign take        = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign ram_re  = take && (in_i.data.opcode == cir_pkg::OP_READ);
  assign end_off = {1'b0, prod_q} + 33'(hdr_q.payload_length);
  assign rcv_inc = rcv_cmp + 16'd1;

  cir_ram #(
    .WIDTH (8),
    .DEPTH (cir_pkg::BUFFER_BYTES)
  ) u_image_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q[AW-1:0]),
    .wdata_i (in_i.data.payload_byte),
    .re_i    (ram_re),
    .raddr_i (in_i.data.read_address[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    fsm_d       = fsm_q;
    active_d    = active_q;
    done_d      = done_q;
    flen_d      = flen_q;
    exp_d       = exp_q;
    rcv_d       = rcv_q;
    bpc_d       = bpc_q;
    wptr_d      = wptr_q;
    left_d      = left_q;
    acc_d       = acc_q;
    rd_status_d = rd_status_q;
    ram_we      = 1'b0;
    load        = 1'b0;
    status      = cir_pkg::ST_OK;
    rdata       = 8'd0;
    act_cmp     = active_q;
    done_cmp    = done_q;
    flen_cmp    = flen_q;
    exp_cmp     = exp_q;
    rcv_cmp     = rcv_q;

    unique case (fsm_q)
      FSM_IDLE: begin
        if (take) begin
          unique case (cir_pkg::op_e'(in_i.data.opcode))
            cir_pkg::OP_HEADER: begin
              fsm_d = FSM_HDR;
            end
            cir_pkg::OP_BYTE: begin
              load = 1'b1;
              if (left_q == 16'd0) begin
                status = cir_pkg::ST_IGNORED;
              end else begin
                left_d = left_q - 16'd1;
                if (acc_q && (wptr_q < BUF_END)) begin
                  ram_we = 1'b1;
                  wptr_d = wptr_q + PW'(1);
                  status = cir_pkg::ST_OK;
                end else begin
                  status = cir_pkg::ST_IGNORED;
                end
              end
            end
            cir_pkg::OP_READ: begin
              fsm_d = FSM_RD;
              if (!(active_q && done_q)) begin
                rd_status_d = cir_pkg::ST_NOT_COMPLETE;
              end else if (PW'(in_i.data.read_address) >= flen_q) begin
                rd_status_d = cir_pkg::ST_OUT_OF_RANGE;
              end else begin
                rd_status_d = cir_pkg::ST_OK;
              end
            end
            cir_pkg::OP_CLEAR: begin
              load     = 1'b1;
              active_d = 1'b0;
              done_d   = 1'b0;
              rcv_d    = 16'd0;
              left_d   = 16'd0;
              acc_d    = 1'b0;
              status   = cir_pkg::ST_OK;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      FSM_HDR: begin
        fsm_d  = FSM_IDLE;
        load   = 1'b1;
        acc_d  = 1'b0;
        left_d = hdr_q.payload_length;
        if (hdr_q.chunk_index == 16'd0) begin
          act_cmp  = 1'b1;
          done_cmp = 1'b0;
          flen_cmp = hdr_q.image_length[PW-1:0];
          exp_cmp  = hdr_q.chunk_count;
          rcv_cmp  = 16'd0;
        end
        priority if (hdr_q.payload_length == 16'd0) begin
          status = cir_pkg::ST_EMPTY;
        end else if (hdr_q.magic_value != magic_q) begin
          status = cir_pkg::ST_BAD_MAGIC;
        end else if (hdr_q.image_length > 32'(cir_pkg::BUFFER_BYTES)) begin
          status = cir_pkg::ST_TOO_LARGE;
        end else if (hdr_q.chunk_index >= hdr_q.chunk_count) begin
          status = cir_pkg::ST_BAD_INDEX;
        end else begin
          active_d = act_cmp;
          done_d   = done_cmp;
          flen_d   = flen_cmp;
          exp_d    = exp_cmp;
          rcv_d    = rcv_cmp;
          if (hdr_q.chunk_index == 16'd0) begin
            bpc_d = hdr_q.payload_length;
          end
          priority if (!act_cmp || done_cmp) begin
            status = cir_pkg::ST_IGNORED;
          end else if ((hdr_q.image_length != 32'(flen_cmp)) ||
                       (hdr_q.chunk_count != exp_cmp)) begin
            status = cir_pkg::ST_MISMATCH;
          end else if (end_off > 33'(cir_pkg::BUFFER_BYTES)) begin
            status = cir_pkg::ST_OVERFLOW;
          end else begin
            status = cir_pkg::ST_OK;
            wptr_d = prod_q[PW-1:0];
            acc_d  = 1'b1;
            rcv_d  = rcv_inc;
            done_d = (rcv_inc == exp_cmp);
          end
        end
      end
      FSM_RD: begin
        fsm_d  = FSM_IDLE;
        load   = 1'b1;
        status = rd_status_q;
        rdata  = (rd_status_q == cir_pkg::ST_OK) ? ram_rdata : 8'd0;
      end
      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d                 = 1'b1;
      out_data_d.status           = status;
      out_data_d.read_data        = rdata;
      out_data_d.frame_complete   = active_d && done_d;
      out_data_d.chunks_seen      = rcv_d;
      out_data_d.assembled_length = flen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_IDLE;
      magic_q     <= cir_pkg::MAGIC_RESET;
      active_q    <= 1'b0;
      done_q      <= 1'b0;
      flen_q      <= '0;
      exp_q       <= '0;
      rcv_q       <= '0;
      bpc_q       <= '0;
      wptr_q      <= '0;
      left_q      <= '0;
      acc_q       <= 1'b0;
      rd_status_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      active_q    <= active_d;
      done_q      <= done_d;
      flen_q      <= flen_d;
      exp_q       <= exp_d;
      rcv_q       <= rcv_d;
      bpc_q       <= bpc_d;
      wptr_q      <= wptr_d;
      left_q      <= left_d;
      acc_q       <= acc_d;
      rd_status_q <= rd_status_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        magic_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (take && (in_i.data.opcode == cir_pkg::OP_HEADER)) begin
      hdr_q  <= in_i.data;
      prod_q <= in_i.data.chunk_index * bpc_q;
    end
  end

endmodule
